### src/lage_pkg.sv
package lage_pkg;

  localparam int DEF_ROWS = 64;
  localparam int DEF_COLS = 64;

  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADV  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    NS_EMPTY = 2'd0,
    NS_LIVES = 2'd1,
    NS_DIES  = 2'd2
  } next_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_ADV,
    ST_READ,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_SET,
    WR_FRESH
  } wr_mode_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_ACK,
    RES_CELL
  } res_kind_t;

  typedef struct packed {
    logic      load_req;
    logic      rd_en;
    logic      wr_en;
    wr_mode_t  wr_mode;
    logic      win_clear;
    logic      win_shift;
    logic      shift_zero;
    logic      res_load;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic col_in;
  } dp_status_t;

  // live cells among the eight around the center of a 3x3 patch
  function automatic logic [3:0] nbr_count(input logic [2:0] a, input logic [2:0] m,
                                           input logic [2:0] b);
    nbr_count = 4'(a[0]) + 4'(a[1]) + 4'(a[2]) + 4'(m[0]) + 4'(m[2])
              + 4'(b[0]) + 4'(b[1]) + 4'(b[2]);
  endfunction

  function automatic logic next_alive(input logic alive, input logic [3:0] n);
    if (alive) begin
      next_alive = (n == SURVIVE_LO) || (n == BIRTH_CNT);
    end else begin
      next_alive = (n == BIRTH_CNT);
    end
  endfunction

endpackage

### src/lage_req_if.sv
interface lage_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] cell_row;
  logic [5:0] cell_col;

  modport source (output valid, output opcode, output cell_row, output cell_col,
                  input ready);
  modport sink (input valid, input opcode, input cell_row, input cell_col,
                output ready);
endinterface

### src/lage_rsp_if.sv
interface lage_rsp_if;
  logic       valid;
  logic       ready;
  logic       cell_alive;
  logic [3:0] neighbour_count;
  logic [1:0] next_status;
  logic       done_res;

  modport source (output valid, output cell_alive, output neighbour_count,
                  output next_status, output done_res, input ready);
  modport sink (input valid, input cell_alive, input neighbour_count,
                input next_status, input done_res, output ready);
endinterface

### src/lage_datapath.sv
module lage_datapath
  import lage_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS,
  localparam int RW = $clog2(ROWS)
) (
  input  logic            clk,
  input  dp_cmd_t         cmd,
  input  logic [RW-1:0]   rd_addr,
  input  logic [RW-1:0]   wr_addr,
  input  logic [5:0]      in_col,
  output dp_status_t      status,
  output logic            cell_alive,
  output logic [3:0]      neighbour_count,
  output logic [1:0]      next_status,
  output logic            done_res
);

  logic [COLS-1:0] grid [ROWS];
  logic [COLS-1:0] rdata;
  logic [COLS-1:0] wdata;
  logic [COLS-1:0] fresh;

  logic [5:0]      col;
  logic [COLS-1:0] above;
  logic [COLS-1:0] mid;
  logic [COLS-1:0] below;
  logic [COLS+1:0] pad_a;
  logic [COLS+1:0] pad_m;
  logic [COLS+1:0] pad_b;

  logic [3:0]      rd_n;
  logic            rd_alive;
  logic            rd_next;
  next_status_t    rd_status;

  // grid memory, one row per word
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      grid[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= grid[rd_addr];
    end
  end

  // three-row window
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      col <= in_col;
    end
    if (cmd.win_clear) begin
      above <= '0;
      mid   <= '0;
      below <= '0;
    end else if (cmd.win_shift) begin
      above <= mid;
      mid   <= below;
      below <= cmd.shift_zero ? '0 : rdata;
    end
  end

  assign pad_a = {1'b0, above, 1'b0};
  assign pad_m = {1'b0, mid, 1'b0};
  assign pad_b = {1'b0, below, 1'b0};

  // next generation of the middle row, one rule cell per column
  for (genvar c = 0; c < COLS; c++) begin : g_col
    logic [3:0] n;
    assign n        = nbr_count(pad_a[c +: 3], pad_m[c +: 3], pad_b[c +: 3]);
    assign fresh[c] = next_alive(pad_m[c+1], n);
  end

  always_comb begin
    case (cmd.wr_mode)
      WR_SET:   wdata = rdata | (COLS'(1) << col);
      WR_FRESH: wdata = fresh;
      default:  wdata = '0;
    endcase
  end

  assign status.col_in = {1'b0, col} < 7'(COLS);

  // single-cell report
  assign rd_n     = nbr_count(pad_a[col +: 3], pad_m[col +: 3], pad_b[col +: 3]);
  assign rd_alive = pad_m[{1'b0, col} + 7'd1];
  assign rd_next  = next_alive(rd_alive, rd_n);

  always_comb begin
    if (rd_next) begin
      rd_status = NS_LIVES;
    end else if (rd_alive) begin
      rd_status = NS_DIES;
    end else begin
      rd_status = NS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RES_ACK: begin
          cell_alive      <= 1'b0;
          neighbour_count <= 4'd0;
          next_status     <= NS_EMPTY;
          done_res        <= 1'b1;
        end
        RES_CELL: begin
          cell_alive      <= rd_alive;
          neighbour_count <= rd_n;
          next_status     <= rd_status;
          done_res        <= 1'b1;
        end
        default: begin
          cell_alive      <= 1'b0;
          neighbour_count <= 4'd0;
          next_status     <= NS_EMPTY;
          done_res        <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/lage_ctrl.sv
module lage_ctrl
  import lage_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  localparam int RW = $clog2(ROWS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_opcode,
  input  logic [5:0]    in_row,
  output logic          out_valid,
  input  logic          out_ready,
  input  dp_status_t    status,
  output dp_cmd_t       cmd,
  output logic [RW-1:0] rd_addr,
  output logic [RW-1:0] wr_addr
);

  localparam int XW = ((RW > 6) ? RW : 6) + 2;
  localparam int CW = $clog2(ROWS + 3);

  state_t       state;
  state_t       state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] cnt_m3;
  opcode_t      op;
  logic [5:0]   row;
  logic         pend;

  logic [XW-1:0] row_x;
  logic [XW-1:0] base;
  logic [XW-1:0] rd_idx;
  logic          rd_in;
  logic          addr_ok;

  assign row_x  = XW'(row);
  // advance walks from row 0, a read from the row above the cell
  assign base   = (op == OP_ADV) ? XW'(0) : row_x - XW'(1);
  assign rd_idx = base + XW'(cnt);
  assign rd_in  = rd_idx < XW'(ROWS);
  assign addr_ok = (row_x < XW'(ROWS)) && status.col_in;
  assign cnt_m3 = cnt - CW'(3);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == CW'(ROWS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode_t'(in_opcode))
            OP_SET:  state_next = ST_SET;
            OP_ADV:  state_next = ST_ADV;
            OP_READ: state_next = ST_READ;
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_SET: begin
        if (cnt != '0) state_next = ST_RESP;
      end
      ST_ADV: begin
        if (cnt == CW'(ROWS + 2)) state_next = ST_RESP;
      end
      ST_READ: begin
        if (cnt == CW'(3)) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    rd_addr  = rd_idx[RW-1:0];
    wr_addr  = cnt_m3[RW-1:0];
    case (state)
      ST_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_mode = WR_ZERO;
        wr_addr     = cnt[RW-1:0];
      end
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_SET: begin
        rd_addr     = row_x[RW-1:0];
        wr_addr     = row_x[RW-1:0];
        cmd.wr_mode = WR_SET;
        if (cnt == '0) begin
          cmd.rd_en = addr_ok;
        end else begin
          cmd.wr_en = addr_ok;
        end
      end
      ST_ADV: begin
        cmd.win_clear  = (cnt == '0);
        cmd.rd_en      = rd_in;
        cmd.win_shift  = (cnt != '0) && (cnt <= CW'(ROWS + 1));
        cmd.shift_zero = !pend;
        cmd.wr_en      = (cnt >= CW'(3));
        cmd.wr_mode    = WR_FRESH;
      end
      ST_READ: begin
        cmd.win_clear  = (cnt == '0);
        cmd.rd_en      = (cnt < CW'(3)) && rd_in;
        cmd.win_shift  = (cnt != '0);
        cmd.shift_zero = !pend;
      end
      ST_RESP: begin
        cmd.res_load = !out_valid || out_ready;
        case (op)
          OP_SET, OP_ADV: cmd.res_kind = RES_ACK;
          OP_READ:        cmd.res_kind = addr_ok ? RES_CELL : RES_ACK;
          default:        cmd.res_kind = RES_NONE;
        endcase
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign cnt_next = ((state_next != state) || (state == ST_IDLE)) ? '0 : cnt + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= cmd.rd_en;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= opcode_t'(in_opcode);
      row <= in_row;
    end
  end

  // never read a row in the cycle it is rewritten
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of the same grid row");

  // a result only lands in a free output register
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result overwrote a pending transaction");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

  // window never cleared and shifted together
  a_win: assert property (@(posedge clk) disable iff (rst)
    !(cmd.win_clear && cmd.win_shift))
    else $error("window clear and shift at once");

endmodule

### src/life_automaton_grid_engine_top.sv
// channel | dir | payload                                             | handshake
// req     | in  | opcode, cell_row, cell_col                          | valid/ready
// rsp     | out | cell_alive, neighbour_count, next_status, done_res  | valid/ready
//
// one request in flight; a finished result sits in the output register while the
// next request is taken
// set reads and rewrites one row; read fetches three rows through the one memory read port
// advance: one grid row read and one rewritten per cycle
// after reset a clearing pass zeroes the grid, req.ready stays low
// a stalled rsp holds the block in its result state until the register frees
module life_automaton_grid_engine_top
  import lage_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input logic       clk,
  input logic       rst,
  lage_req_if.sink  req,
  lage_rsp_if.source rsp
);

  localparam int RW = $clog2(ROWS);

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [RW-1:0] rd_addr;
  logic [RW-1:0] wr_addr;

  // sequencer: clearing pass, set, advance and read timing
  lage_ctrl #(
    .ROWS (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_opcode (req.opcode),
    .in_row    (req.cell_row),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  // grid memory, three-row window, rule logic and result register
  lage_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .rd_addr         (rd_addr),
    .wr_addr         (wr_addr),
    .in_col          (req.cell_col),
    .status          (status),
    .cell_alive      (rsp.cell_alive),
    .neighbour_count (rsp.neighbour_count),
    .next_status     (rsp.next_status),
    .done_res        (rsp.done_res)
  );

endmodule

### tb/lage_cell_report_checker.sv
`timescale 1ns / 100ps

module lage_cell_report_checker
  import lage_pkg::*;
#(
  parameter int ROWS = DEF_ROWS,
  parameter int COLS = DEF_COLS
) (
  input  logic clk,
  input  logic rst,
  lage_req_if  req,
  lage_rsp_if  rsp,
  output int   mismatches,
  output int   awaited,
  output int   requests_seen,
  output int   generations,
  output int   live_reads
);

  typedef struct packed {
    logic       alive;
    logic [3:0] count;
    logic [1:0] status;
    logic       done;
  } cell_report_t;

  logic [COLS-1:0] life_grid [ROWS];
  cell_report_t    report_q [$];

  // columns beyond the edges read as dead
  function automatic logic cell_at(input logic [COLS-1:0] bits, input int c);
    if (c < 0 || c >= COLS) begin
      return 1'b0;
    end
    return bits[c];
  endfunction

  function automatic logic [3:0] live_around(input logic [COLS-1:0] above,
                                             input logic [COLS-1:0] mid,
                                             input logic [COLS-1:0] below, input int c);
    logic [3:0] n;
    n = '0;
    for (int d = -1; d <= 1; d++) begin
      n += 4'(cell_at(above, c + d));
      n += 4'(cell_at(below, c + d));
      if (d != 0) begin
        n += 4'(cell_at(mid, c + d));
      end
    end
    return n;
  endfunction

  function automatic logic lives_on(input logic alive, input logic [3:0] n);
    if (alive) begin
      return (n == SURVIVE_LO) || (n == BIRTH_CNT);
    end
    return n == BIRTH_CNT;
  endfunction

  // whole new generation from the old one, row by row
  function automatic void step_generation();
    logic [COLS-1:0] above;
    logic [COLS-1:0] mid;
    logic [COLS-1:0] below;
    logic [COLS-1:0] fresh;
    above = '0;
    for (int r = 0; r < ROWS; r++) begin
      mid   = life_grid[r];
      below = (r + 1 < ROWS) ? life_grid[r+1] : '0;
      fresh = '0;
      for (int c = 0; c < COLS; c++) begin
        fresh[c] = lives_on(mid[c], live_around(above, mid, below, c));
      end
      above        = mid;
      life_grid[r] = fresh;
    end
  endfunction

  function automatic cell_report_t apply_request(input opcode_t op, input logic [5:0] row,
                                                 input logic [5:0] col);
    cell_report_t    rep;
    logic            in_grid;
    logic [COLS-1:0] above;
    logic [COLS-1:0] below;
    rep     = '0;
    in_grid = (int'(row) < ROWS) && (int'(col) < COLS);
    case (op)
      OP_SET: begin
        if (in_grid) begin
          life_grid[row][col] = 1'b1;
        end
        rep.done = 1'b1;
      end
      OP_ADV: begin
        step_generation();
        rep.done = 1'b1;
      end
      OP_READ: begin
        if (in_grid) begin
          above     = (row > 0) ? life_grid[row-1] : '0;
          below     = (int'(row) + 1 < ROWS) ? life_grid[int'(row)+1] : '0;
          rep.alive = life_grid[row][col];
          rep.count = live_around(above, life_grid[row], below, int'(col));
          if (lives_on(rep.alive, rep.count)) begin
            rep.status = NS_LIVES;
          end else if (rep.alive) begin
            rep.status = NS_DIES;
          end else begin
            rep.status = NS_EMPTY;
          end
        end
        rep.done = 1'b1;
      end
      default: begin
        // unknown opcode answers all zeros
      end
    endcase
    return rep;
  endfunction

  always @(posedge clk) begin
    cell_report_t want;
    cell_report_t got;
    if (rst) begin
      foreach (life_grid[r]) life_grid[r] = '0;
      report_q.delete();
      mismatches    = 0;
      requests_seen = 0;
      generations   = 0;
      live_reads    = 0;
    end else begin
      // result side first: a result never belongs to a request taken at the same edge
      if (rsp.valid && rsp.ready) begin
        got = '{alive: rsp.cell_alive, count: rsp.neighbour_count,
                status: rsp.next_status, done: rsp.done_res};
        if (report_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result alive=%0d count=%0d status=%0d done=%0d",
                     $time, got.alive, got.count, got.status, got.done);
          end
          mismatches++;
        end else begin
          want = report_q.pop_front();
          if (got.alive !== want.alive || got.count !== want.count ||
              got.status !== want.status || got.done !== want.done) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch, expected alive=%0d count=%0d status=%0d done=%0d",
                       $time, want.alive, want.count, want.status, want.done);
              $display("%0t:                  got alive=%0d count=%0d status=%0d done=%0d",
                       $time, got.alive, got.count, got.status, got.done);
            end
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        want = apply_request(opcode_t'(req.opcode), req.cell_row, req.cell_col);
        report_q.push_back(want);
        requests_seen++;
        if (opcode_t'(req.opcode) == OP_ADV) generations++;
        if (opcode_t'(req.opcode) == OP_READ && want.alive) live_reads++;
      end
    end
    awaited = report_q.size();
  end

endmodule

### tb/tb_life_automaton_grid_engine_top.sv
`timescale 1ns / 100ps

module tb_life_automaton_grid_engine_top;
  import lage_pkg::*;

  localparam int ROWS           = DEF_ROWS;
  localparam int COLS           = DEF_COLS;
  // long receiver hold-off, well past what fills the block and stalls its input
  localparam int LONG_HOLD      = 300;
  // cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;

  // idle percentages, written by the stimulus only at a falling edge
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  bit long_hold_req = 1'b0;

  int idle_cycles = 0;

  // counters handed up by the checker
  int mismatches;
  int awaited;
  int requests_seen;
  int generations;
  int live_reads;

  lage_req_if req_ch ();
  lage_rsp_if rsp_ch ();

  life_automaton_grid_engine_top #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // watches both channels, predicts every result and compares
  lage_cell_report_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .requests_seen (requests_seen),
    .generations   (generations),
    .live_reads    (live_reads)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result receiver: random back-pressure, plus one long hold-off when armed
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (long_hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // hang detection: any transaction on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, awaited);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request transaction, with random idle cycles ahead of it
  task automatic offer_request(input opcode_t op, input logic [5:0] row,
                               input logic [5:0] col);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.cell_row <= row;
    req_ch.cell_col <= col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // sender pauses until every outstanding result is back, then the next phase starts
  task automatic drain_and_switch(input int tx_pct, input int rx_pct, input bit arm_hold);
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    tx_idle_pct   = tx_pct;
    rx_idle_pct   = rx_pct;
    long_hold_req = long_hold_req | arm_hold;
    @(posedge clk);
  endtask

  // mostly sets and reads clustered in a small window so patterns form and evolve,
  // mixed with generation steps, scattered accesses and the unused opcode
  task automatic random_burst(input int count);
    logic [5:0] base_r;
    logic [5:0] base_c;
    logic [5:0] r;
    logic [5:0] c;
    int         kind;
    base_r = '0;
    base_c = '0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        // window near the far edges wraps in 6 bits, so it straddles the grid border
        base_r = ($urandom_range(3) == 0) ? 6'd60 : 6'($urandom);
        base_c = ($urandom_range(3) == 0) ? 6'd60 : 6'($urandom);
      end
      r    = base_r + 6'($urandom_range(7));
      c    = base_c + 6'($urandom_range(7));
      kind = $urandom_range(99);
      if (kind < 45) begin
        offer_request(OP_SET, r, c);
      end else if (kind < 72) begin
        offer_request(OP_READ, r, c);
      end else if (kind < 77) begin
        offer_request(OP_READ, 6'($urandom), 6'($urandom));
      end else if (kind < 82) begin
        offer_request(OP_SET, 6'($urandom), 6'($urandom));
      end else if (kind < 97) begin
        offer_request(OP_ADV, 6'($urandom), 6'($urandom));
      end else begin
        offer_request(OP_NONE, 6'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin
    req_ch.valid    <= 1'b0;
    req_ch.opcode   <= OP_SET;
    req_ch.cell_row <= '0;
    req_ch.cell_col <= '0;
    rst             <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: corner cluster, birth on a dead corner neighbour, corner survivor
    offer_request(OP_SET, 6'd0, 6'd0);
    offer_request(OP_SET, 6'd0, 6'd1);
    offer_request(OP_SET, 6'd1, 6'd0);
    offer_request(OP_READ, 6'd1, 6'd1);
    offer_request(OP_READ, 6'd0, 6'd0);
    // lone cell in the far corner dies, its diagonal neighbour sees one
    offer_request(OP_SET, 6'd63, 6'd63);
    offer_request(OP_READ, 6'd63, 6'd63);
    offer_request(OP_READ, 6'd62, 6'd62);
    // blinker: middle survives, cell above is born
    offer_request(OP_SET, 6'd10, 6'd20);
    offer_request(OP_SET, 6'd10, 6'd21);
    offer_request(OP_SET, 6'd10, 6'd22);
    offer_request(OP_READ, 6'd10, 6'd21);
    offer_request(OP_READ, 6'd9, 6'd21);
    // unused opcode gives an all-zero result
    offer_request(OP_NONE, 6'd63, 6'd63);
    offer_request(OP_ADV, 6'd0, 6'd0);
    offer_request(OP_READ, 6'd9, 6'd21);
    // ring of eight around a dead cell: full neighbour count
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if (dr != 1 || dc != 1) begin
          offer_request(OP_SET, 6'(30 + dr), 6'(40 + dc));
        end
      end
    end
    offer_request(OP_READ, 6'd31, 6'd41);

    // random phases: sender-light/receiver-heavy idling, then swapped
    drain_and_switch(27, 52, 1'b0);
    random_burst(420);
    drain_and_switch(52, 27, 1'b0);
    random_burst(420);
    // no idling, with one long receiver hold-off while requests keep coming
    drain_and_switch(0, 0, 1'b1);
    random_burst(410);
    drain_and_switch(0, 0, 1'b0);

    // a generation step is the longest thing the block does
    repeat (ROWS + 8) @(posedge clk);

    $display("run covered %0d requests with %0d generation steps", requests_seen, generations);
    $display("%0d reads found a live cell, idling varied on both channels", live_reads);
    if (mismatches == 0 && awaited == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
